/* rtl/gpnc_pkg.sv */
// Shared widths, register indexes and pipeline item types for the gated PID noise canceller.
package gpnc_pkg;

    // Fixed-point format of the gains and width of the integral accumulator.
    localparam int GAIN_FRAC_BITS = 12;
    localparam int ACC_WIDTH      = 40;

    // Datapath widths that follow from the 16-bit samples and gains.
    localparam int SAMPLE_W = 16;
    localparam int GAIN_W   = 16;
    localparam int ERR_W    = SAMPLE_W + 1;
    localparam int DIFF_W   = ERR_W + 1;
    localparam int PROD_W   = ERR_W + GAIN_W;
    localparam int DPROD_W  = DIFF_W + GAIN_W;
    localparam int PD_W     = DPROD_W + 1;
    // Room for accumulator plus the proportional and derivative terms without overflow.
    localparam int TOT_W    = ACC_WIDTH + 2;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_GATE = 8'd3;

    // Register values after reset.
    localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 16'd1024;
    localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 16'd0;
    localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 16'd205;
    localparam logic [GAIN_W-1:0] NOISE_GATE_RST = 16'd500;

    // Accumulator saturation limits.
    localparam logic [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
    localparam logic [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

    // Output clamp limit, symmetric so that negation never wraps.
    localparam logic [SAMPLE_W-1:0] OUT_LIMIT = 16'd32767;

    typedef struct packed {
        logic [GAIN_W-1:0]   prop_gain;
        logic [GAIN_W-1:0]   integ_gain;
        logic [GAIN_W-1:0]   deriv_gain;
        logic [SAMPLE_W-1:0] noise_gate;
    } cfg_t;

    // Error stage item: gate decision, error and change of error.
    typedef struct packed {
        logic              gate_open;
        logic [ERR_W-1:0]  err;
        logic [DIFF_W-1:0] diff;
    } err_item_t;

    // Controller sum item ahead of scaling and clamping.
    typedef struct packed {
        logic             gate_open;
        logic [TOT_W-1:0] total;
    } sum_item_t;

endpackage

/* rtl/gpnc_cfg.sv */
// Configuration register file for gains and noise gate.
module gpnc_cfg (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [gpnc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]               cfg_data,
    output gpnc_pkg::cfg_t            cfg
);
    import gpnc_pkg::*;

    cfg_t cfg_reg;

    // Writes are always taken; unknown indexes are dropped.
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prop_gain  <= PROP_GAIN_RST;
            cfg_reg.integ_gain <= INTEG_GAIN_RST;
            cfg_reg.deriv_gain <= DERIV_GAIN_RST;
            cfg_reg.noise_gate <= NOISE_GATE_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_PROP_GAIN:  cfg_reg.prop_gain  <= cfg_data;
                CFG_INTEG_GAIN: cfg_reg.integ_gain <= cfg_data;
                CFG_DERIV_GAIN: cfg_reg.deriv_gain <= cfg_data;
                CFG_NOISE_GATE: cfg_reg.noise_gate <= cfg_data;
                default:        ;
            endcase
        end
    end

endmodule

/* rtl/gpnc_err.sv */
// Input register, noise gate decision and error computation.
module gpnc_err (
    input  logic                        clk,
    input  logic                        rst_n,
    input  gpnc_pkg::cfg_t              cfg,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [gpnc_pkg::SAMPLE_W-1:0] noise_sample,
    input  logic [gpnc_pkg::SAMPLE_W-1:0] feedback_sample,
    output logic                        out_valid,
    input  logic                        out_ready,
    output gpnc_pkg::err_item_t         out_item
);
    import gpnc_pkg::*;

    logic                in_vld_reg;
    logic [SAMPLE_W-1:0] noise_reg;
    logic [SAMPLE_W-1:0] fb_reg;
    logic                err_vld_reg;
    err_item_t           err_item_reg;
    logic [ERR_W-1:0]    last_error_reg;

    logic                err_ready;
    logic signed [ERR_W-1:0]  noise_ext;
    logic signed [ERR_W-1:0]  fb_ext;
    logic [ERR_W-1:0]         mag;
    logic                     gate_open;
    logic signed [ERR_W-1:0]  err;
    logic signed [DIFF_W-1:0] diff;

    // Each stage moves when it is empty or the next one takes its item.
    assign err_ready = !err_vld_reg || out_ready;
    assign in_ready  = !in_vld_reg || err_ready;
    assign out_valid = err_vld_reg;
    assign out_item  = err_item_reg;

    // Gate on noise magnitude, then error and its change since the last open item.
    always_comb
    begin
        noise_ext = ERR_W'($signed(noise_reg));
        fb_ext    = ERR_W'($signed(fb_reg));
        mag       = noise_ext[ERR_W-1] ? 17'(-noise_ext) : noise_ext;
        gate_open = mag > {1'b0, cfg.noise_gate};
        err       = fb_ext - noise_ext;
        diff      = DIFF_W'(err) - DIFF_W'($signed(last_error_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg     <= 1'b0;
            err_vld_reg    <= 1'b0;
            last_error_reg <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                in_vld_reg <= in_valid;
            end
            if (err_ready)
            begin
                err_vld_reg <= in_vld_reg;
            end
            // The previous error only follows items that ran the controller.
            if (in_vld_reg && err_ready && gate_open)
            begin
                last_error_reg <= err;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            noise_reg <= noise_sample;
            fb_reg    <= feedback_sample;
        end
        if (in_vld_reg && err_ready)
        begin
            err_item_reg.gate_open <= gate_open;
            err_item_reg.err       <= err;
            err_item_reg.diff      <= diff;
        end
    end

endmodule

/* rtl/gpnc_pid.sv */
// Gain products, saturating integral accumulator and three-term sum.
module gpnc_pid (
    input  logic                clk,
    input  logic                rst_n,
    input  gpnc_pkg::cfg_t      cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  gpnc_pkg::err_item_t in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output gpnc_pkg::sum_item_t out_item
);
    import gpnc_pkg::*;

    // Product stage.
    logic               prd_vld_reg;
    logic               prd_open_reg;
    logic [PROD_W-1:0]  pprod_reg;
    logic [PROD_W-1:0]  iprod_reg;
    logic [DPROD_W-1:0] dprod_reg;
    // Accumulate stage.
    logic               acc_vld_reg;
    logic               acc_open_reg;
    logic [ACC_WIDTH-1:0] acc_val_reg;
    logic [PD_W-1:0]    pd_reg;
    // Sum stage.
    logic               sum_vld_reg;
    sum_item_t          sum_item_reg;
    // Controller state.
    logic [ACC_WIDTH-1:0] integ_accum_reg;

    logic prd_ready;
    logic acc_ready;
    logic sum_ready;

    logic signed [PROD_W-1:0]  pprod;
    logic signed [PROD_W-1:0]  iprod;
    logic signed [DPROD_W-1:0] dprod;
    logic signed [ACC_WIDTH:0] acc_sum;
    logic [ACC_WIDTH-1:0]      acc_sat;
    logic signed [PD_W-1:0]    pd_sum;
    logic signed [TOT_W-1:0]   total;

    assign sum_ready = !sum_vld_reg || out_ready;
    assign acc_ready = !acc_vld_reg || sum_ready;
    assign prd_ready = !prd_vld_reg || acc_ready;
    assign in_ready  = prd_ready;
    assign out_valid = sum_vld_reg;
    assign out_item  = sum_item_reg;

    // Three parallel gain multipliers.
    always_comb
    begin
        pprod = PROD_W'($signed(in_item.err)) * PROD_W'($signed(cfg.prop_gain));
        iprod = PROD_W'($signed(in_item.err)) * PROD_W'($signed(cfg.integ_gain));
        dprod = DPROD_W'($signed(in_item.diff)) * DPROD_W'($signed(cfg.deriv_gain));
    end

    // Saturating integral update and proportional plus derivative sum.
    always_comb
    begin
        acc_sum = (ACC_WIDTH+1)'($signed(integ_accum_reg))
                + (ACC_WIDTH+1)'($signed(iprod_reg));
        if (acc_sum[ACC_WIDTH] != acc_sum[ACC_WIDTH-1])
        begin
            acc_sat = acc_sum[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
        end
        else
        begin
            acc_sat = acc_sum[ACC_WIDTH-1:0];
        end
        pd_sum = PD_W'($signed(pprod_reg)) + PD_W'($signed(dprod_reg));
    end

    // Final sum of the three terms.
    assign total = TOT_W'($signed(acc_val_reg)) + TOT_W'($signed(pd_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prd_vld_reg     <= 1'b0;
            acc_vld_reg     <= 1'b0;
            sum_vld_reg     <= 1'b0;
            integ_accum_reg <= '0;
        end
        else
        begin
            if (prd_ready)
            begin
                prd_vld_reg <= in_valid;
            end
            if (acc_ready)
            begin
                acc_vld_reg <= prd_vld_reg;
            end
            if (sum_ready)
            begin
                sum_vld_reg <= acc_vld_reg;
            end
            // The accumulator advances once for each item that ran the controller.
            if (prd_vld_reg && acc_ready && prd_open_reg)
            begin
                integ_accum_reg <= acc_sat;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_valid && prd_ready)
        begin
            prd_open_reg <= in_item.gate_open;
            pprod_reg    <= pprod;
            iprod_reg    <= iprod;
            dprod_reg    <= dprod;
        end
        if (prd_vld_reg && acc_ready)
        begin
            acc_open_reg <= prd_open_reg;
            acc_val_reg  <= acc_sat;
            pd_reg       <= pd_sum;
        end
        if (acc_vld_reg && sum_ready)
        begin
            sum_item_reg.gate_open <= acc_open_reg;
            sum_item_reg.total     <= total;
        end
    end

endmodule

/* rtl/gpnc_out.sv */
// Scaling toward zero, symmetric clamp, negation and the output register.
module gpnc_out (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  gpnc_pkg::sum_item_t        in_item,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [gpnc_pkg::SAMPLE_W-1:0] drive_sample,
    output logic                       gate_open
);
    import gpnc_pkg::*;

    localparam logic [TOT_W-1:0] ROUND_BIAS = TOT_W'((1 << GAIN_FRAC_BITS) - 1);
    localparam logic signed [TOT_W-1:0] OUT_MAX = TOT_W'(OUT_LIMIT);
    localparam logic signed [TOT_W-1:0] OUT_MIN = -OUT_MAX;

    logic                  out_vld_reg;
    logic [SAMPLE_W-1:0]   drive_reg;
    logic                  open_reg;

    logic signed [TOT_W-1:0]    adj;
    logic signed [TOT_W-1:0]    quot;
    logic signed [SAMPLE_W-1:0] clamped;
    logic [SAMPLE_W-1:0]        drive;

    assign in_ready     = !out_vld_reg || out_ready;
    assign out_valid    = out_vld_reg;
    assign drive_sample = drive_reg;
    assign gate_open    = open_reg;

    // Divide by the gain scale with truncation toward zero, clamp and negate; a gated item drives zero.
    always_comb
    begin
        adj = $signed(in_item.total)
            + (in_item.total[TOT_W-1] ? $signed(ROUND_BIAS) : $signed(TOT_W'(0)));
        quot = adj >>> GAIN_FRAC_BITS;
        if (quot > OUT_MAX)
        begin
            clamped = $signed(OUT_LIMIT);
        end
        else if (quot < OUT_MIN)
        begin
            clamped = -$signed(OUT_LIMIT);
        end
        else
        begin
            clamped = quot[SAMPLE_W-1:0];
        end
        drive = in_item.gate_open ? SAMPLE_W'(-clamped) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_vld_reg <= in_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            drive_reg <= drive;
            open_reg  <= in_item.gate_open;
        end
    end

endmodule

/* rtl/gated_pid_noise_canceller.sv */
// Top level of the gated PID noise canceller.
//
// Usage:
//   The slave stream takes one stereo frame per item: tdata holds the noise
//   reference sample in bits 15:0 and the feedback microphone sample in 31:16.
//   The master stream gives one result per frame: tdata holds the signed
//   speaker drive sample, which feeds both speaker channels, and tuser holds
//   the gate flag (1 when the controller ran, 0 when the frame was gated and
//   the drive is silence).
//   The configuration channel writes one of four registers per cycle and is
//   always ready: 0 proportional gain, 1 integral gain, 2 derivative gain
//   (all signed Q4.12) and 3 noise gate. Other indexes are ignored. Write it
//   only while no frame is in flight.
//   A result passes the six pipeline registers (input, error, products,
//   accumulate, sum, output) in that order, each holding one item. Throughput
//   is one frame per cycle while the master side does not stall.
//   Reset clears the gains to their defaults, the previous error and the
//   integral accumulator to zero, and empties the pipeline.
//   When the receiver stalls, items collect in the pipeline and the slave
//   side keeps accepting until every stage is full.
module gated_pid_noise_canceller (
    input  logic        clk,
    input  logic        rst_n,
    // Slave stream: [15:0] noise_sample, [31:16] feedback_sample.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,
    // Master stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [15:0] drive_sample.
    output logic [15:0] m_axis_tdata,
    // [0] gate_open.
    output logic        m_axis_tuser,
    // Configuration writes.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [gpnc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0] cfg_data
);
    import gpnc_pkg::*;

    cfg_t      cfg;
    logic      err_valid;
    logic      err_ready;
    err_item_t err_item;
    logic      sum_valid;
    logic      sum_ready;
    sum_item_t sum_item;

    // Register file.
    gpnc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Gate decision and error.
    gpnc_err u_err (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg),
        .in_valid        (s_axis_tvalid),
        .in_ready        (s_axis_tready),
        .noise_sample    (s_axis_tdata[15:0]),
        .feedback_sample (s_axis_tdata[31:16]),
        .out_valid       (err_valid),
        .out_ready       (err_ready),
        .out_item        (err_item)
    );

    // Controller terms and integral state.
    gpnc_pid u_pid (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (err_valid),
        .in_ready  (err_ready),
        .in_item   (err_item),
        .out_valid (sum_valid),
        .out_ready (sum_ready),
        .out_item  (sum_item)
    );

    // Scaling, clamp and output register.
    gpnc_out u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (sum_valid),
        .in_ready     (sum_ready),
        .in_item      (sum_item),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .drive_sample (m_axis_tdata),
        .gate_open    (m_axis_tuser)
    );

endmodule
